// ===== hw/rtl/risc_instruction_executor_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the instruction executor
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef RISC_INSTRUCTION_EXECUTOR_MACROS_SVH
`define RISC_INSTRUCTION_EXECUTOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define RIE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RIE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RIE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define RIE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/rie_pkg.sv =====
// ----------------------------------------------------------------------------
// Instruction executor package
// Opcodes, default sizes and the beat types of the input and result channels.
// ----------------------------------------------------------------------------
package rie_pkg;

    // Data path word width.
    localparam int WORD_W = 32;

    // Default sizes of the data memory and register file.
    localparam int MEM_WORDS_DEF = 1024;
    localparam int REG_COUNT_DEF = 32;

    // Byte step of the program counter.
    localparam int PC_STEP = 4;

    // Opcodes.
    localparam logic [4:0] OP_ADD     = 5'd0;
    localparam logic [4:0] OP_ADDI    = 5'd1;
    localparam logic [4:0] OP_SUB     = 5'd2;
    localparam logic [4:0] OP_SUBI    = 5'd3;
    localparam logic [4:0] OP_MUL     = 5'd4;
    localparam logic [4:0] OP_MULI    = 5'd5;
    localparam logic [4:0] OP_OR      = 5'd6;
    localparam logic [4:0] OP_ORI     = 5'd7;
    localparam logic [4:0] OP_AND     = 5'd8;
    localparam logic [4:0] OP_ANDI    = 5'd9;
    localparam logic [4:0] OP_XOR     = 5'd10;
    localparam logic [4:0] OP_XORI    = 5'd11;
    localparam logic [4:0] OP_LDW     = 5'd12;
    localparam logic [4:0] OP_STW     = 5'd13;
    localparam logic [4:0] OP_BZ      = 5'd14;
    localparam logic [4:0] OP_BEQ     = 5'd15;
    localparam logic [4:0] OP_JR      = 5'd16;
    localparam logic [4:0] OP_HALT    = 5'd17;
    localparam logic [4:0] OP_PRELOAD = 5'd18;

    // One decoded instruction.
    typedef struct packed {
        logic [4:0]         op;
        logic [4:0]         src_reg;
        logic [4:0]         second_reg;
        logic [4:0]         dest_reg;
        logic signed [15:0] imm_value;
        logic [9:0]         preload_index;
        logic [31:0]        preload_data;
    } t_in_beat;

    // Machine status after one instruction.
    typedef struct packed {
        logic [31:0] next_pc;
        logic        halted;
        logic        bad_opcode;
        logic        bad_address;
        logic        pc_out_of_range;
        logic [31:0] total_count;
        logic [31:0] arith_count;
        logic [31:0] logic_count;
        logic [31:0] mem_count;
        logic [31:0] ctrl_count;
    } t_out_beat;

endpackage

// ===== hw/rtl/rie_ram.sv =====
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port; the read data is registered and shows
// the contents from before a write to the same address in that cycle.
// ----------------------------------------------------------------------------
module rie_ram import rie_pkg::*; #(
    parameter int  WIDTH = WORD_W,
    parameter int  DEPTH = REG_COUNT_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/risc_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// Instruction executor
// The block executes one decoded instruction per beat and returns one status
// beat for each. It accepts one instruction every cycle unless stalled by the
// clearing pass or by a held status beat. The register file RAMs are read at
// the accepting edge; the instruction then executes from the execute stage
// register (ALU, multiplier, data memory access, pc and counter update) and
// its status is registered. Register results are written back from the
// pending write register, and operands are forwarded from the pending and
// the last write so dependent instructions can follow back to back. After
// reset the data memory is cleared one word a cycle, during which no
// instruction is accepted. A halt freezes the machine until the next reset.
// ----------------------------------------------------------------------------
`include "risc_instruction_executor_macros.svh"

module risc_instruction_executor import rie_pkg::*; #(
    parameter int MEM_WORDS = MEM_WORDS_DEF,
    parameter int REG_COUNT = REG_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out
);

    localparam int          AW        = $clog2(MEM_WORDS);
    localparam int          RW        = $clog2(REG_COUNT);
    localparam int          RIW       = 6;
    localparam logic [RIW-1:0] REG_LIMIT = RIW'(REG_COUNT);
    localparam logic [31:0] MEM_BYTES = 32'(MEM_WORDS * 4);
    localparam logic [31:0] MEM_LIMIT = 32'(MEM_WORDS);
    localparam logic [AW-1:0] CLR_LAST = AW'(MEM_WORDS - 1);

    // Handshake and pipeline control.
    logic      out_blocked;
    logic      s2_fire;
    logic      in_fire;
    logic      s2_hold;
    t_in_beat  r_s2;
    logic      r_s2_valid;

    // Architectural state held in flip-flops.
    logic [31:0] r_pc;
    logic        r_halt;
    logic [31:0] r_cnt_total, r_cnt_arith, r_cnt_logic, r_cnt_mem, r_cnt_ctrl;
    logic [REG_COUNT-1:0] r_reg_valid;

    // Write-back and forwarding registers.
    logic        r_wb_valid;
    logic [4:0]  r_wb_idx;
    logic [31:0] r_wb_data;
    logic        r_wb_load;
    logic        r_lw_valid;
    logic [4:0]  r_lw_idx;
    logic [31:0] r_lw_data;
    logic [31:0] wb_fwd_data;

    // Memory clearing pass.
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // Output register.
    t_out_beat r_out;
    logic      r_out_valid;

    // RAM ports.
    logic [4:0]    rd_a_idx, rd_b_idx;
    logic [31:0]   rf_a_q, rf_b_q;
    logic [31:0]   dm_q;
    logic          dm_we_port;
    logic [AW-1:0] dm_waddr_port;
    logic [31:0]   dm_wdata_port;

    // Execute stage signals.
    logic          rs_ok, rt_ok, rd_ok;
    logic [31:0]   opa, opb;
    logic [31:0]   imm32;
    logic [31:0]   alu_b;
    logic [31:0]   mul_res;
    logic [31:0]   mem_addr;
    logic          addr_ok;
    logic          pidx_ok;
    logic [31:0]   pc4, br_tgt;
    logic [31:0]   n_pc;
    logic          n_halt;
    logic          bad_op, bad_addr;
    logic          cls_arith, cls_logic, cls_mem, cls_ctrl, cls_total;
    logic          wb_en;
    logic [4:0]    wb_idx;
    logic [31:0]   wb_data;
    logic          wb_load;
    logic          dm_we;
    logic [AW-1:0] dm_waddr;
    logic [31:0]   dm_wdata;

    // Stall the input while clearing, or while the execute stage cannot drain.
    assign out_blocked = r_out_valid && i_out_stall;
    assign s2_fire     = r_s2_valid && !out_blocked;
    assign o_in_stall  = r_clr_busy || (r_s2_valid && out_blocked);
    assign in_fire     = i_in_valid && !o_in_stall;
    assign s2_hold     = r_s2_valid && !s2_fire;

    // Execute stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (in_fire) begin
            r_s2_valid <= 1'b1;
        end else if (s2_fire) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s2 <= i_in;
        end
    end

    // Register file read: a held instruction re-reads its operands each cycle.
    assign rd_a_idx = s2_hold ? r_s2.src_reg    : i_in.src_reg;
    assign rd_b_idx = s2_hold ? r_s2.second_reg : i_in.second_reg;

    assign wb_fwd_data = r_wb_load ? dm_q : r_wb_data;

    rie_ram #(
        .WIDTH (WORD_W),
        .DEPTH (REG_COUNT)
    ) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (r_wb_valid),
        .i_waddr (r_wb_idx[RW-1:0]),
        .i_wdata (wb_fwd_data),
        .i_raddr (rd_a_idx[RW-1:0]),
        .o_rdata (rf_a_q)
    );

    rie_ram #(
        .WIDTH (WORD_W),
        .DEPTH (REG_COUNT)
    ) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (r_wb_valid),
        .i_waddr (r_wb_idx[RW-1:0]),
        .i_wdata (wb_fwd_data),
        .i_raddr (rd_b_idx[RW-1:0]),
        .o_rdata (rf_b_q)
    );

    // Data memory, written by the clearing pass or by the execute stage.
    assign dm_we_port    = r_clr_busy || (s2_fire && dm_we);
    assign dm_waddr_port = r_clr_busy ? r_clr_addr : dm_waddr;
    assign dm_wdata_port = r_clr_busy ? 32'd0 : dm_wdata;

    rie_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_WORDS)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_we    (dm_we_port),
        .i_waddr (dm_waddr_port),
        .i_wdata (dm_wdata_port),
        .i_raddr (mem_addr[AW+1:2]),
        .o_rdata (dm_q)
    );

    // Register index range checks.
    assign rs_ok = {1'b0, r_s2.src_reg} < REG_LIMIT;
    assign rt_ok = {1'b0, r_s2.second_reg} < REG_LIMIT;
    assign rd_ok = {1'b0, r_s2.dest_reg} < REG_LIMIT;

    // Operand A: pending write first, then last write, then the RAM.
    always_comb begin
        if (!rs_ok) begin
            opa = 32'd0;
        end else if (r_wb_valid && (r_wb_idx == r_s2.src_reg)) begin
            opa = wb_fwd_data;
        end else if (r_lw_valid && (r_lw_idx == r_s2.src_reg)) begin
            opa = r_lw_data;
        end else if (r_reg_valid[r_s2.src_reg[RW-1:0]]) begin
            opa = rf_a_q;
        end else begin
            opa = 32'd0;
        end
    end

    // Operand B, with the same priority.
    always_comb begin
        if (!rt_ok) begin
            opb = 32'd0;
        end else if (r_wb_valid && (r_wb_idx == r_s2.second_reg)) begin
            opb = wb_fwd_data;
        end else if (r_lw_valid && (r_lw_idx == r_s2.second_reg)) begin
            opb = r_lw_data;
        end else if (r_reg_valid[r_s2.second_reg[RW-1:0]]) begin
            opb = rf_b_q;
        end else begin
            opb = 32'd0;
        end
    end

    // Shared operand preparation. Odd codes below the loads are immediates.
    assign imm32    = {{16{r_s2.imm_value[15]}}, r_s2.imm_value};
    assign alu_b    = r_s2.op[0] ? imm32 : opb;
    assign mul_res  = opa * alu_b;
    assign mem_addr = opa + imm32;
    assign addr_ok  = mem_addr < MEM_BYTES;
    assign pidx_ok  = 32'(r_s2.preload_index) < MEM_LIMIT;
    assign pc4      = r_pc + 32'(PC_STEP);
    assign br_tgt   = r_pc + {imm32[29:0], 2'b00};

    // Execute: decode the instruction and work out the next state.
    always_comb begin
        n_pc      = r_pc;
        n_halt    = r_halt;
        bad_op    = 1'b0;
        bad_addr  = 1'b0;
        cls_total = 1'b0;
        cls_arith = 1'b0;
        cls_logic = 1'b0;
        cls_mem   = 1'b0;
        cls_ctrl  = 1'b0;
        wb_en     = 1'b0;
        wb_idx    = r_s2.op[0] ? r_s2.second_reg : r_s2.dest_reg;
        wb_data   = 32'd0;
        wb_load   = 1'b0;
        dm_we     = 1'b0;
        dm_waddr  = mem_addr[AW+1:2];
        dm_wdata  = opb;
        if (!r_halt) begin
            unique case (r_s2.op) inside
                OP_ADD, OP_ADDI: begin
                    wb_data   = opa + alu_b;
                    cls_arith = 1'b1;
                end
                OP_SUB, OP_SUBI: begin
                    wb_data   = opa - alu_b;
                    cls_arith = 1'b1;
                end
                OP_MUL, OP_MULI: begin
                    wb_data   = mul_res;
                    cls_arith = 1'b1;
                end
                OP_OR, OP_ORI: begin
                    wb_data   = opa | alu_b;
                    cls_logic = 1'b1;
                end
                OP_AND, OP_ANDI: begin
                    wb_data   = opa & alu_b;
                    cls_logic = 1'b1;
                end
                OP_XOR, OP_XORI: begin
                    wb_data   = opa ^ alu_b;
                    cls_logic = 1'b1;
                end
                OP_LDW: begin
                    wb_idx   = r_s2.second_reg;
                    wb_load  = 1'b1;
                    bad_addr = !addr_ok;
                    cls_mem  = 1'b1;
                end
                OP_STW: begin
                    dm_we    = addr_ok;
                    bad_addr = !addr_ok;
                    cls_mem  = 1'b1;
                end
                OP_BZ: begin
                    cls_ctrl = 1'b1;
                end
                OP_BEQ: begin
                    cls_ctrl = 1'b1;
                end
                OP_JR: begin
                    cls_ctrl = 1'b1;
                end
                OP_HALT: begin
                    n_halt   = 1'b1;
                    cls_ctrl = 1'b1;
                end
                OP_PRELOAD: begin
                    dm_we    = pidx_ok;
                    dm_waddr = AW'(32'(r_s2.preload_index));
                    dm_wdata = r_s2.preload_data;
                    bad_addr = !pidx_ok;
                end
                default: begin
                    bad_op    = 1'b1;
                    cls_total = 1'b1;
                end
            endcase

            // Known instructions other than preload advance or redirect pc.
            if (cls_arith || cls_logic || cls_mem || cls_ctrl) begin
                cls_total = 1'b1;
                n_pc      = pc4;
                if ((r_s2.op == OP_BZ) && (opa == 32'd0)) begin
                    n_pc = br_tgt;
                end
                if ((r_s2.op == OP_BEQ) && (opa == opb)) begin
                    n_pc = br_tgt;
                end
                if (r_s2.op == OP_JR) begin
                    n_pc = opa;
                end
            end

            // Register write enable, with the destination range check.
            if (cls_arith || cls_logic) begin
                wb_en = r_s2.op[0] ? rt_ok : rd_ok;
            end else if (wb_load) begin
                wb_en = addr_ok && rt_ok;
            end
        end
    end

    // Program counter, halt flag and class counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= 32'd0;
            r_halt      <= 1'b0;
            r_cnt_total <= 32'd0;
            r_cnt_arith <= 32'd0;
            r_cnt_logic <= 32'd0;
            r_cnt_mem   <= 32'd0;
            r_cnt_ctrl  <= 32'd0;
        end else if (s2_fire) begin
            r_pc        <= n_pc;
            r_halt      <= n_halt;
            r_cnt_total <= r_cnt_total + 32'(cls_total);
            r_cnt_arith <= r_cnt_arith + 32'(cls_arith);
            r_cnt_logic <= r_cnt_logic + 32'(cls_logic);
            r_cnt_mem   <= r_cnt_mem + 32'(cls_mem);
            r_cnt_ctrl  <= r_cnt_ctrl + 32'(cls_ctrl);
        end
    end

    // Pending register write; the load data arrives from the memory next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_valid <= 1'b0;
        end else begin
            r_wb_valid <= s2_fire && wb_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_wb_idx  <= wb_idx;
            r_wb_data <= wb_data;
            r_wb_load <= wb_load;
        end
    end

    // Last completed register write and the written marks of the file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw_valid  <= 1'b0;
            r_reg_valid <= '0;
        end else if (r_wb_valid) begin
            r_lw_valid                    <= 1'b1;
            r_reg_valid[r_wb_idx[RW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_wb_valid) begin
            r_lw_idx  <= r_wb_idx;
            r_lw_data <= wb_fwd_data;
        end
    end

    // Clearing pass over the data memory after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == CLR_LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Status beat register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_out.next_pc         <= n_pc;
            r_out.halted          <= n_halt;
            r_out.bad_opcode      <= bad_op;
            r_out.bad_address     <= bad_addr;
            r_out.pc_out_of_range <= n_pc >= MEM_BYTES;
            r_out.total_count     <= r_cnt_total + 32'(cls_total);
            r_out.arith_count     <= r_cnt_arith + 32'(cls_arith);
            r_out.logic_count     <= r_cnt_logic + 32'(cls_logic);
            r_out.mem_count       <= r_cnt_mem + 32'(cls_mem);
            r_out.ctrl_count      <= r_cnt_ctrl + 32'(cls_ctrl);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // An executed instruction always leaves a status beat behind.
    `RIE_ASSERT_NEXT(a_exec_gives_beat, i_clk, i_rst_n, s2_fire, r_out_valid, "status beat lost")
    // Once halted the machine stays halted.
    `RIE_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, r_halt, r_halt, "halt flag dropped")
    // A halted machine never writes the register file.
    `RIE_ASSERT_NEXT(a_halt_no_wb, i_clk, i_rst_n, s2_fire && r_halt, !r_wb_valid, "write while halted")
    // Nothing executes while the memory is still being cleared.
    `RIE_ASSERT_SAME(a_clear_quiet, i_clk, i_rst_n, r_clr_busy, !r_s2_valid && !r_wb_valid, "work during clear")
    // Write-backs only target registers that exist.
    `RIE_ASSERT_SAME(a_wb_in_range, i_clk, i_rst_n, r_wb_valid, {1'b0, r_wb_idx} < REG_LIMIT, "bad write index")

endmodule

// ===== tb/sv/risc_instruction_executor_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Instruction executor regression
// Drives decoded instructions into the executor and checks every status beat
// against a cycle-free software copy of the machine (pc, registers, data
// memory, halt flag and class counters). The run covers a directed list of
// operand and opcode corner cases, a long random program with idle bursts on
// both channels, a long output hold-off that fills the pipeline, and a halt
// that must freeze the machine.
// ----------------------------------------------------------------------------
module risc_instruction_executor_test;
    import rie_pkg::*;

    localparam int          CLK_HALF        = 4;
    localparam int          RESET_CYCLES    = 11;
    localparam logic [31:0] MEM_BYTES       = 32'(MEM_WORDS_DEF * PC_STEP);
    localparam logic [4:0]  OP_MAX          = 5'd31;
    localparam int          RANDOM_ITEMS    = 780;
    localparam int          PRESSURE_ITEMS  = 48;
    localparam int          HOLD_OFF_CYCLES = 200;
    localparam int          DRAIN_CYCLES    = 16;
    // Covers the memory clear pass after reset plus the long hold-off.
    localparam int          WATCHDOG_LIMIT  = 4000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_beat  i_in;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_beat o_out;

    // Software copy of the machine state.
    logic [31:0] shadow_pc;
    logic [31:0] shadow_regs [REG_COUNT_DEF];
    logic [31:0] shadow_mem [MEM_WORDS_DEF];
    logic        shadow_halted;
    logic [31:0] cnt_total;
    logic [31:0] cnt_arith;
    logic [31:0] cnt_logic;
    logic [31:0] cnt_mem;
    logic [31:0] cnt_ctrl;

    t_out_beat expected_status [$];

    int  error_count;
    int  instrs_sent;
    int  beats_checked;
    int  idle_cycles;
    bit  tx_idle_enable;
    bit  rx_idle_enable;
    bit  hold_off_request;

    risc_instruction_executor u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // Executes one instruction on the software copy and returns its status.
    // With 32 registers and a 10-bit preload index every index is in range.
    function automatic t_out_beat predict_status(t_in_beat ins);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] imm32;
        logic [31:0] addr;
        logic [31:0] next;
        logic        bad_op;
        logic        bad_addr;
        t_out_beat   st;
        a        = shadow_regs[ins.src_reg];
        b        = shadow_regs[ins.second_reg];
        imm32    = {{16{ins.imm_value[15]}}, ins.imm_value};
        bad_op   = 1'b0;
        bad_addr = 1'b0;
        if (!shadow_halted) begin
            if (ins.op == OP_PRELOAD) begin
                shadow_mem[ins.preload_index] = ins.preload_data;
            end else if (ins.op > OP_PRELOAD) begin
                cnt_total++;
                bad_op = 1'b1;
            end else begin
                next = shadow_pc + PC_STEP;
                cnt_total++;
                case (ins.op)
                    OP_ADD:  shadow_regs[ins.dest_reg]   = a + b;
                    OP_ADDI: shadow_regs[ins.second_reg] = a + imm32;
                    OP_SUB:  shadow_regs[ins.dest_reg]   = a - b;
                    OP_SUBI: shadow_regs[ins.second_reg] = a - imm32;
                    OP_MUL:  shadow_regs[ins.dest_reg]   = a * b;
                    OP_MULI: shadow_regs[ins.second_reg] = a * imm32;
                    OP_OR:   shadow_regs[ins.dest_reg]   = a | b;
                    OP_ORI:  shadow_regs[ins.second_reg] = a | imm32;
                    OP_AND:  shadow_regs[ins.dest_reg]   = a & b;
                    OP_ANDI: shadow_regs[ins.second_reg] = a & imm32;
                    OP_XOR:  shadow_regs[ins.dest_reg]   = a ^ b;
                    OP_XORI: shadow_regs[ins.second_reg] = a ^ imm32;
                    OP_LDW, OP_STW: begin
                        // The two low address bits are dropped.
                        addr = a + imm32;
                        if (addr < MEM_BYTES) begin
                            if (ins.op == OP_LDW) begin
                                shadow_regs[ins.second_reg] = shadow_mem[addr[11:2]];
                            end else begin
                                shadow_mem[addr[11:2]] = b;
                            end
                        end else begin
                            bad_addr = 1'b1;
                        end
                    end
                    OP_BZ: begin
                        if (a == '0) next = shadow_pc + (imm32 << 2);
                    end
                    OP_BEQ: begin
                        if (a == b) next = shadow_pc + (imm32 << 2);
                    end
                    OP_JR:   next = a;
                    default: shadow_halted = 1'b1;
                endcase
                if (ins.op <= OP_MULI) begin
                    cnt_arith++;
                end else if (ins.op <= OP_XORI) begin
                    cnt_logic++;
                end else if (ins.op <= OP_STW) begin
                    cnt_mem++;
                end else begin
                    cnt_ctrl++;
                end
                shadow_pc = next;
            end
        end
        st.next_pc         = shadow_pc;
        st.halted          = shadow_halted;
        st.bad_opcode      = bad_op;
        st.bad_address     = bad_addr;
        st.pc_out_of_range = (shadow_pc >= MEM_BYTES);
        st.total_count     = cnt_total;
        st.arith_count     = cnt_arith;
        st.logic_count     = cnt_logic;
        st.mem_count       = cnt_mem;
        st.ctrl_count      = cnt_ctrl;
        return st;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
            error_count++;
        end
    endfunction

    // Compares one status beat with the oldest expected status.
    function automatic void check_status(t_out_beat got);
        t_out_beat want;
        if (expected_status.size() == 0) begin
            $error("status beat with no instruction outstanding: next_pc 0x%08h", got.next_pc);
            error_count++;
        end else begin
            want = expected_status.pop_front();
            compare_field("next_pc", want.next_pc, got.next_pc);
            compare_field("halted", 32'(want.halted), 32'(got.halted));
            compare_field("bad_opcode", 32'(want.bad_opcode), 32'(got.bad_opcode));
            compare_field("bad_address", 32'(want.bad_address), 32'(got.bad_address));
            compare_field("pc_out_of_range", 32'(want.pc_out_of_range),
                          32'(got.pc_out_of_range));
            compare_field("total_count", want.total_count, got.total_count);
            compare_field("arith_count", want.arith_count, got.arith_count);
            compare_field("logic_count", want.logic_count, got.logic_count);
            compare_field("mem_count", want.mem_count, got.mem_count);
            compare_field("ctrl_count", want.ctrl_count, got.ctrl_count);
        end
    endfunction

    // Handshakes are sampled at the falling edge, where both sides are settled.
    // The result side is checked before the new instruction is predicted.
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_status(o_out);
            beats_checked++;
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            expected_status.push_back(predict_status(i_in));
            instrs_sent++;
        end
        if (i_rst_n && ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall))) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
    end

    // Ends the run when no beat has moved for too long.
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: random stall bursts, or one long hold-off on request.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_request) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_off_request = 1'b0;
            end else if (rx_idle_enable && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic t_in_beat make_instr(logic [4:0] op, logic [4:0] rs, logic [4:0] rt,
                                            logic [4:0] rd, logic [15:0] imm,
                                            logic [9:0] pidx = '0, logic [31:0] pdata = '0);
        t_in_beat beat;
        beat.op            = op;
        beat.src_reg       = rs;
        beat.second_reg    = rt;
        beat.dest_reg      = rd;
        beat.imm_value     = imm;
        beat.preload_index = pidx;
        beat.preload_data  = pdata;
        return beat;
    endfunction

    // Offers one instruction beat, after an optional idle burst, and returns
    // at the rising edge that accepts it. Must be called at a rising edge.
    task automatic send_instruction(input t_in_beat beat);
        int gap;
        if (tx_idle_enable && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= beat;
        do begin
            @(negedge i_clk);
        end while (o_in_stall);
        @(posedge i_clk);
    endtask

    // Builds one random instruction, biased so that most memory accesses land
    // inside the data memory and some branches are taken.
    task automatic send_random_instruction();
        t_in_beat    beat;
        logic [95:0] noise;
        logic [31:0] target;
        logic [31:0] offset;
        logic [4:0]  ridx;
        int          pick;
        int          k;
        int          base;
        noise = {$urandom(), $urandom(), $urandom()};
        beat  = noise[$bits(t_in_beat)-1:0];
        pick  = $urandom_range(0, 99);
        if (pick < 4) begin
            beat.op = 5'($urandom_range(OP_PRELOAD + 1, OP_MAX));
        end else if (pick < 10) begin
            beat.op = OP_PRELOAD;
            if ($urandom_range(0, 1)) beat.preload_index = 10'($urandom_range(0, 63));
        end else if (pick < 32) begin
            beat.op = $urandom_range(0, 1) ? OP_LDW : OP_STW;
            if ($urandom_range(0, 99) < 85) begin
                target = $urandom_range(0, 1) ? $urandom_range(0, 255)
                                              : $urandom_range(0, MEM_BYTES - 1);
                offset = target - shadow_regs[beat.src_reg];
                // Out of offset reach: clear the base register first.
                if (offset[31:15] != '0 && offset[31:15] != '1) begin
                    send_instruction(make_instr(OP_ANDI, beat.src_reg, beat.src_reg,
                                                '0, '0));
                    offset = target;
                end
                beat.imm_value = offset[15:0];
            end
        end else if (pick < 44) begin
            k = $urandom_range(0, 2);
            beat.op = (k == 0) ? OP_BZ : (k == 1) ? OP_BEQ : OP_JR;
            if (beat.op == OP_BEQ && $urandom_range(0, 2) == 0) beat.second_reg = beat.src_reg;
            if (beat.op == OP_JR && $urandom_range(0, 1)) begin
                // Prefer a register that brings pc back into memory.
                base = $urandom_range(0, REG_COUNT_DEF - 1);
                for (k = 0; k < REG_COUNT_DEF; k++) begin
                    ridx = 5'((base + k) % REG_COUNT_DEF);
                    if (shadow_regs[ridx] < MEM_BYTES) begin
                        beat.src_reg = ridx;
                        break;
                    end
                end
            end
        end else begin
            beat.op = 5'($urandom_range(OP_ADD, OP_XORI));
        end
        send_instruction(beat);
    endtask

    // Every opcode but halt, with extreme immediates, memory edges and unknown codes.
    task automatic test_directed_ops();
        tx_idle_enable = 1'b1;
        rx_idle_enable = 1'b1;
        send_instruction(make_instr(OP_ADDI, 5'd0, 5'd1, 5'd0, 16'h7FFF));
        send_instruction(make_instr(OP_ADDI, 5'd0, 5'd2, 5'd0, 16'h8000));
        send_instruction(make_instr(OP_ADD, 5'd1, 5'd2, 5'd3, 16'h0000));
        send_instruction(make_instr(OP_SUB, 5'd2, 5'd1, 5'd4, 16'h0000));
        send_instruction(make_instr(OP_SUBI, 5'd1, 5'd5, 5'd0, 16'hFFFF));
        send_instruction(make_instr(OP_MUL, 5'd2, 5'd1, 5'd6, 16'h0000));
        send_instruction(make_instr(OP_MULI, 5'd2, 5'd7, 5'd0, 16'h8000));
        send_instruction(make_instr(OP_OR, 5'd1, 5'd2, 5'd31, 16'h0000));
        // Logic immediates are sign extended too.
        send_instruction(make_instr(OP_ORI, 5'd0, 5'd8, 5'd0, 16'h8000));
        send_instruction(make_instr(OP_AND, 5'd2, 5'd31, 5'd9, 16'h0000));
        send_instruction(make_instr(OP_ANDI, 5'd1, 5'd10, 5'd0, 16'hFFFF));
        send_instruction(make_instr(OP_XOR, 5'd1, 5'd2, 5'd11, 16'h0000));
        send_instruction(make_instr(OP_XORI, 5'd31, 5'd12, 5'd0, 16'hFFFF));
        send_instruction(make_instr(OP_PRELOAD, 5'd0, 5'd0, 5'd0, 16'h0000,
                                    10'd1023, 32'hFFFF_FFFF));
        send_instruction(make_instr(OP_PRELOAD, 5'd0, 5'd0, 5'd0, 16'h0000,
                                    10'd0, 32'h1234_5678));
        // Unaligned top byte reads the last word.
        send_instruction(make_instr(OP_LDW, 5'd0, 5'd13, 5'd0, 16'd4095));
        send_instruction(make_instr(OP_STW, 5'd0, 5'd1, 5'd0, 16'd4));
        send_instruction(make_instr(OP_LDW, 5'd0, 5'd14, 5'd0, 16'd7));
        // Negative and just-past-the-end addresses are skipped.
        send_instruction(make_instr(OP_STW, 5'd0, 5'd1, 5'd0, 16'hFFFC));
        send_instruction(make_instr(OP_LDW, 5'd0, 5'd15, 5'd0, 16'd4096));
        send_instruction(make_instr(OP_BZ, 5'd20, 5'd0, 5'd0, 16'hFFFE));
        send_instruction(make_instr(OP_BZ, 5'd1, 5'd0, 5'd0, 16'h0010));
        send_instruction(make_instr(OP_BEQ, 5'd2, 5'd2, 5'd0, 16'd100));
        send_instruction(make_instr(OP_BEQ, 5'd1, 5'd2, 5'd0, 16'd100));
        send_instruction(make_instr(OP_JR, 5'd31, 5'd0, 5'd0, 16'h0000));
        send_instruction(make_instr(OP_JR, 5'd20, 5'd0, 5'd0, 16'h0000));
        send_instruction(make_instr(OP_PRELOAD + 5'd1, 5'd0, 5'd0, 5'd0, 16'h0000));
        send_instruction(make_instr(OP_MAX, 5'd31, 5'd31, 5'd31, 16'hFFFF));
    endtask

    // Random program in chunks, each with its own idling on either side.
    task automatic test_random_program(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                tx_idle_enable = ($urandom_range(0, 3) != 0);
                rx_idle_enable = ($urandom_range(0, 3) != 0);
            end
            send_random_instruction();
        end
    endtask

    // The result side holds off while instructions keep coming back to back.
    task automatic test_back_pressure();
        tx_idle_enable   = 1'b0;
        rx_idle_enable   = 1'b0;
        hold_off_request = 1'b1;
        repeat (PRESSURE_ITEMS) send_random_instruction();
    endtask

    // After a halt, every instruction must see the frozen machine.
    task automatic test_halt_freeze();
        tx_idle_enable = 1'b0;
        rx_idle_enable = 1'b0;
        send_instruction(make_instr(OP_HALT, 5'd0, 5'd0, 5'd0, 16'h0000));
        send_instruction(make_instr(OP_ADD, 5'd1, 5'd2, 5'd3, 16'h0000));
        send_instruction(make_instr(OP_PRELOAD, 5'd0, 5'd0, 5'd0, 16'h0000,
                                    10'd5, 32'hA5A5_5A5A));
        send_instruction(make_instr(OP_MAX, 5'd0, 5'd0, 5'd0, 16'h0000));
        send_instruction(make_instr(OP_STW, 5'd0, 5'd1, 5'd0, 16'd8));
        send_instruction(make_instr(OP_BZ, 5'd20, 5'd0, 5'd0, 16'h0004));
        send_instruction(make_instr(OP_LDW, 5'd0, 5'd1, 5'd0, 16'd8));
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_in             = '0;
        error_count      = 0;
        instrs_sent      = 0;
        beats_checked    = 0;
        idle_cycles      = 0;
        tx_idle_enable   = 1'b0;
        rx_idle_enable   = 1'b0;
        hold_off_request = 1'b0;
        shadow_pc        = '0;
        shadow_halted    = 1'b0;
        cnt_total        = '0;
        cnt_arith        = '0;
        cnt_logic        = '0;
        cnt_mem          = '0;
        cnt_ctrl         = '0;
        foreach (shadow_regs[k]) shadow_regs[k] = '0;
        foreach (shadow_mem[k]) shadow_mem[k] = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_ops();
        test_random_program(RANDOM_ITEMS);
        test_back_pressure();
        test_halt_freeze();
        i_in_valid <= 1'b0;

        // Drain the pipeline, then keep watching for stray beats.
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d instructions and %0d status beats: all opcodes, preload,",
                 instrs_sent, beats_checked);
        $display("bad address and opcode, branches, jumps, a long output hold-off and halt.");
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rie_pkg.sv
hw/rtl/rie_ram.sv
hw/rtl/risc_instruction_executor.sv
tb/sv/risc_instruction_executor_test.sv
